### design/sqmm_pkg.sv
// Shared types and constants of the square matrix multiply unit.
package sqmm_pkg;

    localparam int DIM_DEFAULT = 4;
    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int C_W         = 35;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [C_W-1:0]    c_elem_t;

    typedef struct packed {
        logic vld;
        logic first;
        logic lastk;
    } mac_ctl_t;

endpackage

### design/sqmm_if.sv
// Valid/ready channel interfaces for the operand pairs and the product elements.
interface sqmm_in_if;
    logic            valid;
    logic            ready;
    sqmm_pkg::elem_t a_elem;
    sqmm_pkg::elem_t b_elem;

    modport source (output valid, output a_elem, output b_elem, input ready);
    modport sink (input valid, input a_elem, input b_elem, output ready);
    modport monitor (input valid, input a_elem, input b_elem, input ready);
endinterface

interface sqmm_out_if;
    logic              valid;
    logic              ready;
    sqmm_pkg::c_elem_t c_elem;
    logic              last;

    modport source (output valid, output c_elem, output last, input ready);
    modport sink (input valid, input c_elem, input last, output ready);
    modport monitor (input valid, input c_elem, input last, input ready);
endinterface

### design/sqmm_mac.sv
// Shared multiply-accumulate unit: one registered product stage and one accumulate stage.
module sqmm_mac
(
    input  logic               clk,
    input  logic               rst_n,
    input  sqmm_pkg::mac_ctl_t ctl,
    input  sqmm_pkg::elem_t    a,
    input  sqmm_pkg::elem_t    b,
    output sqmm_pkg::c_elem_t  sum,
    output logic               sum_vld
);

    localparam int EXT_W = sqmm_pkg::C_W - sqmm_pkg::PROD_W;

    sqmm_pkg::mac_ctl_t ctl_reg;
    sqmm_pkg::prod_t    prod_reg;
    sqmm_pkg::c_elem_t  acc_reg;
    logic               sum_vld_reg;
    sqmm_pkg::c_elem_t  prod_ext;

    assign prod_ext = {{EXT_W{prod_reg[sqmm_pkg::PROD_W-1]}}, prod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg     <= '0;
            sum_vld_reg <= 1'b0;
        end
        else
        begin
            ctl_reg     <= ctl;
            sum_vld_reg <= ctl_reg.vld && ctl_reg.lastk;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.vld)
        begin
            prod_reg <= a * b;
        end
        if (ctl_reg.vld)
        begin
            acc_reg <= ctl_reg.first ? prod_ext : sqmm_pkg::c_elem_t'(acc_reg + prod_ext);
        end
    end

    assign sum     = acc_reg;
    assign sum_vld = sum_vld_reg;

endmodule

### design/square_matrix_multiply_unit.sv
// Top level of the square matrix multiply unit: operand stores, sequencer and output register.
//
//   Channel   Role   Payload                 Transfers per matrix pair
//   operand   sink   a_elem, b_elem (16 b)   DIM*DIM, row-major
//   product   source c_elem (35 b), last     DIM*DIM, row-major, last on the final one
//
// Loading takes one operand pair per cycle while operand.valid is high. Each element of C
// then takes DIM reads through the single multiply-accumulate unit, its two pipeline stages
// and a hand-over into the output register. A stalled product channel holds the sequencer.
// Reset clears the sequencer and the output valid; the operand stores need no clearing.
module square_matrix_multiply_unit
#(
    parameter int DIM = sqmm_pkg::DIM_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    sqmm_in_if.sink   operand,
    sqmm_out_if.source product
);

    localparam int CELLS = DIM * DIM;
    localparam int AW    = $clog2(CELLS);
    localparam int IW    = $clog2(DIM);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [AW-1:0]     load_cnt_reg, load_cnt_next;
    logic [IW-1:0]     row_reg, row_next;
    logic [IW-1:0]     col_reg, col_next;
    logic [IW-1:0]     k_reg, k_next;
    logic              done_reg, done_next;
    logic              out_valid_reg, out_valid_next;
    sqmm_pkg::c_elem_t c_reg;
    logic              last_reg;

    sqmm_pkg::elem_t    a_mem [CELLS];
    sqmm_pkg::elem_t    b_mem [CELLS];
    sqmm_pkg::elem_t    a_rd_reg;
    sqmm_pkg::elem_t    b_rd_reg;
    sqmm_pkg::mac_ctl_t s1_ctl_reg;

    logic              in_xfer;
    logic              issue;
    logic              fin;
    logic [AW-1:0]     a_addr;
    logic [AW-1:0]     b_addr;
    sqmm_pkg::c_elem_t mac_sum;
    logic              mac_sum_vld;

    assign operand.ready = (state_reg == ST_LOAD);
    assign in_xfer       = operand.valid && operand.ready;

    assign a_addr = AW'(AW'(row_reg) * AW'(DIM)) + AW'(k_reg);
    assign b_addr = AW'(AW'(k_reg) * AW'(DIM)) + AW'(col_reg);

    always_comb
    begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        k_next         = k_reg;
        done_next      = done_reg;
        issue          = 1'b0;
        fin            = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (load_cnt_reg == AW'(CELLS - 1))
                    begin
                        load_cnt_next = '0;
                        row_next      = '0;
                        col_next      = '0;
                        k_next        = '0;
                        state_next    = ST_CALC;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + 1'b1;
                    end
                end
            end
            ST_CALC:
            begin
                issue = 1'b1;
                if (k_reg == IW'(DIM - 1))
                begin
                    k_next     = '0;
                    state_next = ST_WAIT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_WAIT:
            begin
                if (done_reg && (!out_valid_reg || product.ready))
                begin
                    fin       = 1'b1;
                    done_next = 1'b0;
                    if (col_reg == IW'(DIM - 1))
                    begin
                        col_next = '0;
                        if (row_reg == IW'(DIM - 1))
                        begin
                            row_next   = '0;
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            row_next   = row_reg + 1'b1;
                            state_next = ST_CALC;
                        end
                    end
                    else
                    begin
                        col_next   = col_reg + 1'b1;
                        state_next = ST_CALC;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
        if (mac_sum_vld)
        begin
            done_next = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fin)
        begin
            out_valid_next = 1'b1;
        end
        else if (product.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            load_cnt_reg  <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            k_reg         <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            s1_ctl_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            load_cnt_reg   <= load_cnt_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            k_reg          <= k_next;
            done_reg       <= done_next;
            out_valid_reg  <= out_valid_next;
            s1_ctl_reg.vld   <= issue;
            s1_ctl_reg.first <= (k_reg == '0);
            s1_ctl_reg.lastk <= (k_reg == IW'(DIM - 1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            a_mem[load_cnt_reg] <= operand.a_elem;
            b_mem[load_cnt_reg] <= operand.b_elem;
        end
        if (issue)
        begin
            a_rd_reg <= a_mem[a_addr];
            b_rd_reg <= b_mem[b_addr];
        end
        if (fin)
        begin
            c_reg    <= mac_sum;
            last_reg <= (row_reg == IW'(DIM - 1)) && (col_reg == IW'(DIM - 1));
        end
    end

    sqmm_mac u_mac
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (s1_ctl_reg),
        .a       (a_rd_reg),
        .b       (b_rd_reg),
        .sum     (mac_sum),
        .sum_vld (mac_sum_vld)
    );

    assign product.valid  = out_valid_reg;
    assign product.c_elem = c_reg;
    assign product.last   = last_reg;

endmodule

### design/sqmm_checker.sv
// Port-level checker of the square matrix multiply unit and its bind to the top level.
module sqmm_checker
#(
    parameter int DIM = sqmm_pkg::DIM_DEFAULT
)
(
    input logic        clk,
    input logic        rst_n,
    sqmm_in_if.sink    operand,
    sqmm_out_if.source product
);

    localparam int CELLS = DIM * DIM;
    localparam int AW    = $clog2(CELLS);

    logic [AW-1:0] in_cnt_reg, in_cnt_next;
    logic [AW-1:0] out_cnt_reg, out_cnt_next;
    logic          in_xfer;
    logic          out_xfer;

    assign in_xfer  = operand.valid && operand.ready;
    assign out_xfer = product.valid && product.ready;

    assign in_cnt_next  = (in_cnt_reg == AW'(CELLS - 1)) ? '0 : in_cnt_reg + 1'b1;
    assign out_cnt_next = (out_cnt_reg == AW'(CELLS - 1)) ? '0 : out_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                in_cnt_reg <= in_cnt_next;
            end
            if (out_xfer)
            begin
                out_cnt_reg <= out_cnt_next;
            end
        end
    end

    // A stalled product transfer keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        product.valid && !product.ready |=>
            product.valid && $stable(product.c_elem) && $stable(product.last))
        else $error("product payload changed while stalled");

    // The final operand pair of a matrix pair starts the computation.
    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (in_cnt_reg == AW'(CELLS - 1)) |=> !operand.ready)
        else $error("operand still ready after a complete load");

    // The last flag marks exactly every DIM*DIM-th product transfer.
    a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> (product.last == (out_cnt_reg == AW'(CELLS - 1))))
        else $error("last flag on the wrong product element");

    // Only the final element of C may still wait while the next load runs.
    a_overlap_last: assert property (@(posedge clk) disable iff (!rst_n)
        operand.ready && product.valid |-> product.last)
        else $error("loading while an inner product element is pending");

endmodule

bind square_matrix_multiply_unit sqmm_checker #(.DIM(DIM)) u_sqmm_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .operand (operand),
    .product (product)
);

### test/sqmm_product_checker.sv
// Checker that predicts the product matrix from observed operand transfers and compares results.
`timescale 1ns / 1ps

module sqmm_product_checker
#(
    parameter int DIM = sqmm_pkg::DIM_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    sqmm_in_if.monitor  operand,
    sqmm_out_if.monitor product,
    output int          errors,
    output int          pending
);

    localparam int CELLS = DIM * DIM;

    typedef struct {
        sqmm_pkg::c_elem_t c_elem;
        logic              last;
    } product_elem_t;

    sqmm_pkg::elem_t a_matrix [CELLS];
    sqmm_pkg::elem_t b_matrix [CELLS];
    logic [6:0]      load_count;
    product_elem_t   product_queue [$];
    int              error_count = 0;

    assign errors = error_count;

    task automatic queue_product_matrix();
        product_elem_t entry;
        longint        acc;
        for (int i = 0; i < DIM; i++)
        begin
            for (int j = 0; j < DIM; j++)
            begin
                acc = 0;
                for (int k = 0; k < DIM; k++)
                begin
                    acc += longint'(a_matrix[i * DIM + k]) * longint'(b_matrix[k * DIM + j]);
                end
                entry.c_elem = acc[sqmm_pkg::C_W-1:0];
                entry.last   = (i == DIM - 1) && (j == DIM - 1);
                product_queue.push_back(entry);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        product_elem_t expected;
        if (!rst_n)
        begin
            load_count = '0;
        end
        else
        begin
            if (product.valid && product.ready)
            begin
                if (product_queue.size() == 0)
                begin
                    $error("c_elem transfer with nothing expected: actual %0d, last %0b",
                           product.c_elem, product.last);
                    error_count++;
                end
                else
                begin
                    expected = product_queue.pop_front();
                    if (product.c_elem !== expected.c_elem)
                    begin
                        $error("c_elem mismatch: expected %0d, actual %0d",
                               expected.c_elem, product.c_elem);
                        error_count++;
                    end
                    if (product.last !== expected.last)
                    begin
                        $error("last mismatch: expected %0b, actual %0b",
                               expected.last, product.last);
                        error_count++;
                    end
                end
            end
            if (operand.valid && operand.ready)
            begin
                a_matrix[load_count] = operand.a_elem;
                b_matrix[load_count] = operand.b_elem;
                if (load_count == CELLS - 1)
                begin
                    load_count = '0;
                    queue_product_matrix();
                end
                else
                begin
                    load_count++;
                end
            end
        end
        pending = product_queue.size();
    end

endmodule

### test/square_matrix_multiply_unit_test.sv
// Testbench top for the square matrix multiply unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module square_matrix_multiply_unit_test;

    localparam int DIM         = sqmm_pkg::DIM_DEFAULT;
    localparam int CELLS       = DIM * DIM;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int ELEM_MIN    = -32768;
    localparam int ELEM_MAX    = 32767;

    typedef enum int {FILL_FULL, FILL_EXTREME, FILL_SMALL} fill_t;

    logic            clk = 1'b0;
    logic            rst_n;
    int              mismatch_count;
    int              pending_products;
    int              send_idle_pct = 0;
    int              recv_idle_pct = 0;
    logic            long_hold = 1'b0;
    longint          cycle_count = 0;
    sqmm_pkg::elem_t a_matrix [CELLS];
    sqmm_pkg::elem_t b_matrix [CELLS];

    sqmm_in_if  operand ();
    sqmm_out_if product ();

    square_matrix_multiply_unit #(.DIM(DIM)) uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand),
        .product (product)
    );

    sqmm_product_checker #(.DIM(DIM)) product_check
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand),
        .product (product),
        .errors  (mismatch_count),
        .pending (pending_products)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** square_matrix_multiply_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int   hold_left;
        logic held;
        hold_left = 0;
        held = 1'b0;
        product.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold && !held)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                product.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                product.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    function automatic sqmm_pkg::elem_t random_elem(fill_t style);
        int extremes [4];
        int value;
        extremes = '{ELEM_MIN, ELEM_MAX, 0, -1};
        case (style)
            FILL_EXTREME: value = extremes[$urandom_range(0, 3)];
            FILL_SMALL:   value = int'($urandom_range(0, 16)) - 8;
            default:      value = int'($urandom_range(0, 65535));
        endcase
        return sqmm_pkg::elem_t'(value);
    endfunction

    task automatic send_pair(sqmm_pkg::elem_t a, sqmm_pkg::elem_t b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            operand.valid <= 1'b0;
            @(negedge clk);
        end
        operand.valid  <= 1'b1;
        operand.a_elem <= a;
        operand.b_elem <= b;
        do
            @(posedge clk);
        while (!operand.ready);
        @(negedge clk);
    endtask

    task automatic send_matrices();
        for (int n = 0; n < CELLS; n++)
        begin
            send_pair(a_matrix[n], b_matrix[n]);
        end
    endtask

    task automatic send_random_matrices(fill_t style);
        for (int n = 0; n < CELLS; n++)
        begin
            a_matrix[n] = random_elem(style);
            b_matrix[n] = random_elem(style);
        end
        send_matrices();
    endtask

    task automatic wait_for_drain();
        while (pending_products != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        int a_tail [4];
        int b_tail [4];
        a_tail = '{1, -1, ELEM_MIN, ELEM_MAX};
        b_tail = '{-1, 0, ELEM_MAX, ELEM_MIN};
        operand.valid  = 1'b0;
        operand.a_elem = '0;
        operand.b_elem = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 9;
        recv_idle_pct = 76;

        // Rows of A and columns of B at the extremes reach the largest and smallest sums.
        for (int r = 0; r < DIM; r++)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                case (r)
                    0:       a_matrix[r * DIM + c] = sqmm_pkg::elem_t'(ELEM_MIN);
                    1:       a_matrix[r * DIM + c] = sqmm_pkg::elem_t'(ELEM_MAX);
                    2:       a_matrix[r * DIM + c] = (c % 2) ? sqmm_pkg::elem_t'(-1)
                                                             : sqmm_pkg::elem_t'(0);
                    default: a_matrix[r * DIM + c] = sqmm_pkg::elem_t'(a_tail[c % 4]);
                endcase
                case (c)
                    0:       b_matrix[r * DIM + c] = sqmm_pkg::elem_t'(ELEM_MIN);
                    1:       b_matrix[r * DIM + c] = sqmm_pkg::elem_t'(ELEM_MAX);
                    2:       b_matrix[r * DIM + c] = sqmm_pkg::elem_t'(1);
                    default: b_matrix[r * DIM + c] = sqmm_pkg::elem_t'(b_tail[r % 4]);
                endcase
            end
        end
        send_matrices();
        send_random_matrices(FILL_FULL);
        send_random_matrices(FILL_EXTREME);

        operand.valid <= 1'b0;
        wait_for_drain();

        send_idle_pct = 76;
        recv_idle_pct = 9;
        send_random_matrices(FILL_SMALL);
        send_random_matrices(FILL_FULL);

        // The receiver stalls for a long stretch while transfers keep being offered.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        long_hold = 1'b1;
        send_random_matrices(FILL_EXTREME);
        send_random_matrices(FILL_FULL);
        send_random_matrices(FILL_SMALL);

        operand.valid <= 1'b0;
        wait_for_drain();
        repeat (DIM + 8) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("** square_matrix_multiply_unit: PASSED **");
        end
        else
        begin
            $display("** square_matrix_multiply_unit: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
design/sqmm_pkg.sv
design/sqmm_if.sv
design/sqmm_mac.sv
design/square_matrix_multiply_unit.sv
design/sqmm_checker.sv
test/sqmm_product_checker.sv
test/square_matrix_multiply_unit_test.sv
